FILE: hw/rtl/deque_with_value_remove_assert.svh
// assertion macros shared by the deque controller and datapath
`ifndef DEQUE_WITH_VALUE_REMOVE_ASSERT_SVH
`define DEQUE_WITH_VALUE_REMOVE_ASSERT_SVH
`ifndef ASSERT_OFF
`define DWVR_ASSERT_IMP(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);
`define DWVR_ASSERT_NXT(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);
`else
`define DWVR_ASSERT_IMP(name, pre, post, msg)
`define DWVR_ASSERT_NXT(name, pre, post, msg)
`endif
`endif

FILE: hw/rtl/dwvr_pkg.sv
// operation and status codes and controller/datapath interface types for the deque
`default_nettype none
package dwvr_pkg;

   localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
   localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
   localparam logic [2:0] OP_POP_BACK   = 3'd2;
   localparam logic [2:0] OP_POP_FRONT  = 3'd3;
   localparam logic [2:0] OP_REMOVE     = 3'd4;
   localparam logic [2:0] OP_CLEAR      = 3'd5;

   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_EMPTY    = 2'd2;
   localparam logic [1:0] ST_NOTFOUND = 2'd3;

   localparam int OP_W     = 3;
   localparam int STATUS_W = 2;
   localparam int VALUE_W  = 32;

   typedef struct packed {
      logic load;
      logic exec;
      logic scan;
      logic shift;
      logic out_load;
   } dwvr_cmd_type;

   typedef struct packed {
      logic is_remove;
      logic hit;
      logic miss;
      logic shift_done;
   } dwvr_sts_type;

endpackage
`default_nettype wire

FILE: hw/rtl/dwvr_dpath.sv
// deque datapath: entry memory, front pointer, count, scan/shift logic and result register
`default_nettype none
`include "deque_with_value_remove_assert.svh"
module dwvr_dpath #(
   parameter int CAPACITY = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  dwvr_pkg::dwvr_cmd_type                    cmd,
   output dwvr_pkg::dwvr_sts_type                    sts,
   input  logic [dwvr_pkg::OP_W-1:0]                 req_op,
   input  logic signed [dwvr_pkg::VALUE_W-1:0]       req_value,
   output logic [dwvr_pkg::STATUS_W-1:0]             rsp_status,
   output logic [$clog2(CAPACITY+1)-1:0]             rsp_count,
   output logic signed [dwvr_pkg::VALUE_W-1:0]       rsp_front_value,
   output logic signed [dwvr_pkg::VALUE_W-1:0]       rsp_back_value
);
   import dwvr_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int SUM_W = CNT_W + 1;

   function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] base,
                                             input logic [CNT_W-1:0] off);
      logic [SUM_W-1:0] s;
      s = SUM_W'(base) + SUM_W'(off);
      if (s >= SUM_W'(CAPACITY)) begin
         s = s - SUM_W'(CAPACITY);
      end
      return s[IDX_W-1:0];
   endfunction

   logic [VALUE_W-1:0]        mem_ff [CAPACITY];
   logic [VALUE_W-1:0]        rdata_a_ff;
   logic [VALUE_W-1:0]        rdata_b_ff;

   logic [OP_W-1:0]           op_ff;
   logic [VALUE_W-1:0]        value_ff;
   logic [IDX_W-1:0]          front_ff, front_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          idx_ff, idx_in;
   logic [CNT_W-1:0]          wr_ff, wr_in;
   logic                      rvld_ff, rvld_in;
   logic [STATUS_W-1:0]       status_ff, status_in;

   logic [STATUS_W-1:0]       out_status_ff;
   logic [CNT_W-1:0]          out_count_ff;
   logic [VALUE_W-1:0]        out_front_ff;
   logic [VALUE_W-1:0]        out_back_ff;

   logic                      full;
   logic                      empty;
   logic                      issue_ok;
   logic [IDX_W-1:0]          front_dec;
   logic [IDX_W-1:0]          front_inc;
   logic [CNT_W-1:0]          back_off;
   logic [IDX_W-1:0]          addr_a;
   logic [IDX_W-1:0]          addr_b;
   logic                      mem_we;
   logic [IDX_W-1:0]          mem_waddr;
   logic [VALUE_W-1:0]        mem_wdata;

   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign empty     = (count_ff == '0);
   assign issue_ok  = (idx_ff < count_ff);
   assign front_dec = (front_ff == '0) ? IDX_W'(CAPACITY - 1) : front_ff - 1'b1;
   assign front_inc = slot(front_ff, CNT_W'(1));
   assign back_off  = empty ? '0 : count_ff - 1'b1;
   assign addr_a    = (cmd.scan || cmd.shift) ? slot(front_ff, idx_ff) : front_ff;
   assign addr_b    = slot(front_ff, back_off);

   assign sts.is_remove  = (op_ff == OP_REMOVE);
   assign sts.hit        = rvld_ff && (rdata_a_ff == value_ff);
   assign sts.miss       = !rvld_ff && !issue_ok;
   assign sts.shift_done = !rvld_ff;

   // single memory write port
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = slot(front_ff, count_ff);
      mem_wdata = value_ff;
      if (cmd.exec && !full && op_ff == OP_PUSH_BACK) begin
         mem_we = 1'b1;
      end else if (cmd.exec && !full && op_ff == OP_PUSH_FRONT) begin
         mem_we    = 1'b1;
         mem_waddr = front_dec;
      end else if (cmd.shift && rvld_ff) begin
         mem_we    = 1'b1;
         mem_waddr = slot(front_ff, wr_ff);
         mem_wdata = rdata_a_ff;
      end
   end

   always_comb begin
      front_in  = front_ff;
      count_in  = count_ff;
      status_in = status_ff;
      idx_in    = idx_ff;
      wr_in     = wr_ff;
      rvld_in   = rvld_ff;
      if (cmd.load) begin
         status_in = ST_DONE;
         idx_in    = '0;
         rvld_in   = 1'b0;
      end
      if (cmd.exec) begin
         case (op_ff)
            OP_PUSH_BACK: begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
            OP_PUSH_FRONT: begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  front_in = front_dec;
                  count_in = count_ff + 1'b1;
               end
            end
            OP_POP_BACK: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  count_in = count_ff - 1'b1;
               end
            end
            OP_POP_FRONT: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  front_in = front_inc;
                  count_in = count_ff - 1'b1;
               end
            end
            OP_CLEAR: begin
               front_in = '0;
               count_in = '0;
            end
            default: begin
            end
         endcase
      end
      // read one entry ahead while scanning or shifting
      if (cmd.scan || cmd.shift) begin
         if (issue_ok) begin
            idx_in  = idx_ff + 1'b1;
            rvld_in = 1'b1;
         end else begin
            rvld_in = 1'b0;
         end
      end
      if (cmd.scan && sts.hit) begin
         wr_in = idx_ff - 1'b1;
      end
      if (cmd.scan && sts.miss) begin
         status_in = ST_NOTFOUND;
      end
      if (cmd.shift && rvld_ff) begin
         wr_in = wr_ff + 1'b1;
      end
      if (cmd.shift && !rvld_ff) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
         rvld_ff  <= 1'b0;
      end else begin
         front_ff <= front_in;
         count_ff <= count_in;
         rvld_ff  <= rvld_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      idx_ff    <= idx_in;
      wr_ff     <= wr_in;
      if (cmd.load) begin
         op_ff    <= req_op;
         value_ff <= req_value;
      end
      if (cmd.out_load) begin
         out_status_ff <= status_ff;
         out_count_ff  <= count_ff;
         out_front_ff  <= empty ? '0 : rdata_a_ff;
         out_back_ff   <= empty ? '0 : rdata_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
      rdata_a_ff <= mem_ff[addr_a];
      rdata_b_ff <= mem_ff[addr_b];
   end

   assign rsp_status      = out_status_ff;
   assign rsp_count       = out_count_ff;
   assign rsp_front_value = out_front_ff;
   assign rsp_back_value  = out_back_ff;

   `DWVR_ASSERT_IMP(a_count_bound, 1'b1, count_ff <= CNT_W'(CAPACITY), "count above capacity")
   `DWVR_ASSERT_IMP(a_shift_range, cmd.shift && rvld_ff, (wr_ff + 1'b1) < count_ff, "shift out of range")
   `DWVR_ASSERT_IMP(a_push_room, mem_we && cmd.exec, !full, "write into full queue")

endmodule
`default_nettype wire

FILE: hw/rtl/dwvr_ctrl.sv
// deque controller: sequences execute, scan, shift, readout and result beat
`default_nettype none
`include "deque_with_value_remove_assert.svh"
module dwvr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output dwvr_pkg::dwvr_cmd_type cmd,
   input  dwvr_pkg::dwvr_sts_type sts
);
   import dwvr_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_EXEC  = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_SHIFT = 3'd3;
   localparam logic [2:0] ST_READ  = 3'd4;
   localparam logic [2:0] ST_FLUSH = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = sts.is_remove ? ST_SCAN : ST_READ;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.hit) begin
               state_in = ST_SHIFT;
            end else if (sts.miss) begin
               state_in = ST_READ;
            end
         end
         ST_SHIFT: begin
            cmd.shift = 1'b1;
            if (sts.shift_done) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   `DWVR_ASSERT_NXT(a_accept_exec, req_tvalid && req_tready, state_ff == ST_EXEC, "accept did not start execute")
   `DWVR_ASSERT_NXT(a_flush_beat, cmd.out_load, rsp_valid_ff, "result beat not raised")
   `DWVR_ASSERT_IMP(a_one_phase, cmd.scan || cmd.shift, !cmd.exec && !cmd.load, "overlapping phases")

endmodule
`default_nettype wire

FILE: hw/rtl/deque_with_value_remove.sv
// top level of the bounded deque of signed 32-bit values with remove-by-value
//
//   channel  dir  tdata                              tuser
//   req_     in   [31:0] value                       [2:0] op
//   rsp_     out  count, front_value, back_value     [1:0] status
//
// push, pop, clear and unknown ops pass from accept through the execute, read and flush states to the result beat
// remove runs a one-entry-per-cycle scan, then a shift
// of the later entries one per cycle, both on the entry memory's read/write ports
// a new beat is accepted once the previous one has been written to the result register
// reset clears the pointers and count; memory contents stay undefined and are never read
`default_nettype none
module deque_with_value_remove #(
   parameter int CAPACITY = 16
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              req_tvalid,
   output logic                                              req_tready,
   input  logic [31:0]                                       req_tdata,  // value
   input  logic [2:0]                                        req_tuser,  // op
   output logic                                              rsp_tvalid,
   input  logic                                              rsp_tready,
   // count, front_value, back_value
   output logic [(($clog2(CAPACITY+1)+64+7)/8)*8-1:0]        rsp_tdata,
   output logic [1:0]                                        rsp_tuser   // status
);
   import dwvr_pkg::*;

   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int RSP_DATA_W = ((CNT_W + 2 * VALUE_W + 7) / 8) * 8;

   dwvr_cmd_type               cmd;
   dwvr_sts_type               sts;
   logic [CNT_W-1:0]           rsp_count;
   logic signed [VALUE_W-1:0]  rsp_front_value;
   logic signed [VALUE_W-1:0]  rsp_back_value;

   dwvr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   dwvr_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_op          (req_tuser),
      .req_value       (req_tdata),
      .rsp_status      (rsp_tuser),
      .rsp_count       (rsp_count),
      .rsp_front_value (rsp_front_value),
      .rsp_back_value  (rsp_back_value)
   );

   assign rsp_tdata = RSP_DATA_W'({rsp_back_value, rsp_front_value, rsp_count});

endmodule
`default_nettype wire

FILE: tb/deque_with_value_remove_checker.sv
// scoreboard for the deque: mirrors the queue, predicts every result beat and compares it
`default_nettype none
module deque_with_value_remove_checker #(
   parameter int CAPACITY = 16,
   parameter int RSP_W    = 72
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   input  wire logic             req_tready,
   input  wire logic [31:0]      req_tdata,   // value
   input  wire logic [2:0]       req_tuser,   // op
   input  wire logic             rsp_tvalid,
   input  wire logic             rsp_tready,
   input  wire logic [RSP_W-1:0] rsp_tdata,   // count, front_value, back_value
   input  wire logic [1:0]       rsp_tuser,   // status
   output int                    fail_count,
   output int                    pending,
   output int                    checked
);
   timeunit 1ns;
   timeprecision 1ps;
   import dwvr_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef struct packed {
      logic [1:0]       status;
      logic [CNT_W-1:0] count;
      logic [31:0]      front_value;
      logic [31:0]      back_value;
   } deque_view_type;

   logic [31:0]    mirror_store [CAPACITY];
   int             mirror_front;
   int             mirror_count;
   deque_view_type expected_views [$];

   function automatic int slot_of(input int offset);
      return (mirror_front + offset) % CAPACITY;
   endfunction

   function automatic deque_view_type apply_operation(input logic [2:0] op,
                                                       input logic [31:0] value);
      deque_view_type view;
      int             hit;
      int             i;
      view.status = ST_DONE;
      hit = -1;
      case (op)
         OP_PUSH_BACK: begin
            if (mirror_count >= CAPACITY) begin
               view.status = ST_FULL;
            end else begin
               mirror_store[slot_of(mirror_count)] = value;
               mirror_count++;
            end
         end
         OP_PUSH_FRONT: begin
            if (mirror_count >= CAPACITY) begin
               view.status = ST_FULL;
            end else begin
               mirror_front = (mirror_front + CAPACITY - 1) % CAPACITY;
               mirror_store[mirror_front] = value;
               mirror_count++;
            end
         end
         OP_POP_BACK: begin
            if (mirror_count == 0) view.status = ST_EMPTY;
            else mirror_count--;
         end
         OP_POP_FRONT: begin
            if (mirror_count == 0) begin
               view.status = ST_EMPTY;
            end else begin
               mirror_front = slot_of(1);
               mirror_count--;
            end
         end
         OP_REMOVE: begin
            for (i = 0; i < mirror_count && hit < 0; i++)
               if (mirror_store[slot_of(i)] == value) hit = i;
            if (hit < 0) begin
               view.status = ST_NOTFOUND;
            end else begin
               // later entries move one place toward the front
               for (i = hit; i + 1 < mirror_count; i++)
                  mirror_store[slot_of(i)] = mirror_store[slot_of(i + 1)];
               mirror_count--;
            end
         end
         OP_CLEAR: begin
            mirror_front = 0;
            mirror_count = 0;
         end
         default: ;
      endcase
      view.count = CNT_W'(mirror_count);
      if (mirror_count == 0) begin
         view.front_value = '0;
         view.back_value  = '0;
      end else begin
         view.front_value = mirror_store[slot_of(0)];
         view.back_value  = mirror_store[slot_of(mirror_count - 1)];
      end
      return view;
   endfunction

   always @(posedge clock) begin
      deque_view_type   want;
      logic [CNT_W-1:0] got_count;
      logic [31:0]      got_front;
      logic [31:0]      got_back;
      got_count = rsp_tdata[CNT_W-1:0];
      got_front = rsp_tdata[CNT_W+31:CNT_W];
      got_back  = rsp_tdata[CNT_W+63:CNT_W+32];
      if (reset) begin
         mirror_front = 0;
         mirror_count = 0;
         expected_views.delete();
         fail_count = 0;
         checked = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_views.size() == 0) begin
               $error("unexpected result beat: status %0d count %0d", rsp_tuser, got_count);
               fail_count++;
            end else begin
               want = expected_views[0];
               expected_views.delete(0);
               checked++;
               if (rsp_tuser !== want.status) begin
                  $error("status mismatch: expected %0d, got %0d", want.status, rsp_tuser);
                  fail_count++;
               end
               if (got_count !== want.count) begin
                  $error("count mismatch: expected %0d, got %0d", want.count, got_count);
                  fail_count++;
               end
               if (got_front !== want.front_value) begin
                  $error("front_value mismatch: expected %0d, got %0d",
                         $signed(want.front_value), $signed(got_front));
                  fail_count++;
               end
               if (got_back !== want.back_value) begin
                  $error("back_value mismatch: expected %0d, got %0d",
                         $signed(want.back_value), $signed(got_back));
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_views.insert(expected_views.size(),
                                  apply_operation(req_tuser, req_tdata));
      end
      pending = expected_views.size();
   end

endmodule
`default_nettype wire

FILE: tb/tb_deque_with_value_remove.sv
// testbench top for the deque: clock, reset, operation stimulus, result back-pressure, verdict
`default_nettype none
module tb_deque_with_value_remove;
   timeunit 1ns;
   timeprecision 1ps;
   import dwvr_pkg::*;

   localparam int CAPACITY    = 16;
   localparam int RSP_W       = (($clog2(CAPACITY + 1) + 64 + 7) / 8) * 8;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int PHASE_BEATS = 412;
   localparam int HOLD_CYCLES = 400;

   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   typedef enum int {FILL_UP, DRAIN, REMOVE_HEAVY, MIXED} episode_kind_type;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [31:0]      req_tdata;
   logic [2:0]       req_tuser;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic [1:0]       rsp_tuser;

   int          fail_count;
   int          pending;
   int          checked;
   int          send_idle_pct   = 0;
   int          recv_stall_pct  = 0;
   logic        long_hold_armed = 1'b0;
   int          long_hold_count = 0;
   int          cycles          = 0;
   int          ops_sent [8];
   logic [31:0] value_pool [8];

   deque_with_value_remove #(
      .CAPACITY(CAPACITY)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   deque_with_value_remove_checker #(
      .CAPACITY(CAPACITY),
      .RSP_W(RSP_W)
   ) deque_monitor (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .fail_count(fail_count),
      .pending(pending),
      .checked(checked)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Regression FAIL");
      $finish;
   end

   // result side: random stalls plus one long hold once it is armed
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_armed && long_hold_count < HOLD_CYCLES) begin
            rsp_tready <= 1'b0;
            long_hold_count++;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   task automatic send_beat(input logic [2:0] op, input logic [31:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      ops_sent[op]++;
      @(negedge clock);
   endtask

   // small value pool so removes hit and duplicates occur
   function automatic logic [31:0] pick_value();
      int r;
      r = $urandom_range(99);
      if (r < 5) value_pool[$urandom_range(7)] = $urandom;
      if (r < 70) return value_pool[$urandom_range(7)];
      return $urandom;
   endfunction

   function automatic logic [2:0] pick_op(input episode_kind_type kind);
      int r;
      r = $urandom_range(99);
      case (kind)
         FILL_UP: begin
            if (r < 45) return OP_PUSH_BACK;
            if (r < 85) return OP_PUSH_FRONT;
            if (r < 92) return OP_REMOVE;
            if (r < 96) return OP_POP_BACK;
            return OP_POP_FRONT;
         end
         DRAIN: begin
            if (r < 40) return OP_POP_BACK;
            if (r < 80) return OP_POP_FRONT;
            if (r < 90) return OP_REMOVE;
            return OP_PUSH_BACK;
         end
         REMOVE_HEAVY: begin
            if (r < 50) return OP_REMOVE;
            if (r < 70) return OP_PUSH_BACK;
            if (r < 85) return OP_PUSH_FRONT;
            if (r < 93) return OP_POP_FRONT;
            return OP_POP_BACK;
         end
         default: begin
            if (r < 3)  return OP_CLEAR;
            if (r < 5)  return OP_SPARE_6;
            if (r < 7)  return OP_SPARE_7;
            if (r < 26) return OP_PUSH_BACK;
            if (r < 45) return OP_PUSH_FRONT;
            if (r < 64) return OP_POP_BACK;
            if (r < 83) return OP_POP_FRONT;
            return OP_REMOVE;
         end
      endcase
   endfunction

   initial begin
      int               phase;
      int               sent;
      int               episode_len;
      episode_kind_type kind;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_PUSH_BACK;
      foreach (ops_sent[k]) ops_sent[k] = 0;
      value_pool[0] = 32'h0000_0000;
      value_pool[1] = 32'hFFFF_FFFF;
      value_pool[2] = 32'h7FFF_FFFF;
      value_pool[3] = 32'h8000_0000;
      value_pool[4] = 32'h0000_0001;
      value_pool[5] = $urandom;
      value_pool[6] = $urandom;
      value_pool[7] = $urandom;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty queue corners, spare codes, wrap of the front index, extremes
      send_beat(OP_CLEAR,      32'h0000_0000);
      send_beat(OP_POP_BACK,   32'h0000_0000);
      send_beat(OP_POP_FRONT,  32'hFFFF_FFFF);
      send_beat(OP_REMOVE,     32'h0000_0005);
      send_beat(OP_SPARE_6,    32'h1234_5678);
      send_beat(OP_SPARE_7,    32'hEDCB_A987);
      send_beat(OP_PUSH_FRONT, 32'h7FFF_FFFF);
      send_beat(OP_PUSH_BACK,  32'h8000_0000);
      send_beat(OP_PUSH_BACK,  32'h0000_0000);
      send_beat(OP_PUSH_FRONT, 32'hFFFF_FFFF);
      send_beat(OP_REMOVE,     32'h7FFF_FFFF);
      send_beat(OP_REMOVE,     32'h0000_0000);
      send_beat(OP_REMOVE,     32'h0000_0063);
      send_beat(OP_PUSH_BACK,  32'h8000_0000);
      send_beat(OP_REMOVE,     32'h8000_0000);
      send_beat(OP_POP_BACK,   32'h0000_0000);
      send_beat(OP_POP_FRONT,  32'h0000_0000);
      send_beat(OP_PUSH_BACK,  32'h0000_002A);
      send_beat(OP_POP_BACK,   32'h0000_0000);
      send_beat(OP_PUSH_FRONT, 32'h5555_AAAA);
      send_beat(OP_POP_FRONT,  32'h0000_0000);

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct   = 0;
               recv_stall_pct  = 0;
               long_hold_armed = 1'b1;
            end
            1: begin
               send_idle_pct  = 70;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 70;
            end
            default: begin
               send_idle_pct  = 12;
               recv_stall_pct = 12;
            end
         endcase
         sent = 0;
         while (sent < PHASE_BEATS) begin
            kind = episode_kind_type'($urandom_range(3));
            episode_len = $urandom_range(30, 8);
            repeat (episode_len) begin
               send_beat(pick_op(kind), pick_value());
               sent++;
            end
         end
      end
      req_tvalid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("sent %0d push, %0d pop, %0d remove, %0d clear and %0d spare-code beats",
               ops_sent[OP_PUSH_BACK] + ops_sent[OP_PUSH_FRONT],
               ops_sent[OP_POP_BACK] + ops_sent[OP_POP_FRONT],
               ops_sent[OP_REMOVE], ops_sent[OP_CLEAR],
               ops_sent[OP_SPARE_6] + ops_sent[OP_SPARE_7]);
      $display("%0d results compared over four idle/stall mixes and one long result hold",
               checked);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
`default_nettype wire
